### design/obv_pkg.sv
`default_nettype none
package obv_pkg;

  // input and fraction format
  localparam int IN_WIDTH  = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = FRAC_BITS + 2;

  // magnitude, square and sum of squares
  localparam int MW  = IN_WIDTH;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;

  // square root recurrence: remainder, cross term, result
  localparam int WW    = SW + FRAC_BITS + 4;
  localparam int RW    = SW + 2 * FRAC_BITS + 6;
  localparam int NSTEP = FRAC_BITS + 1;
  localparam int MQW   = FRAC_BITS + 1;
  localparam int LANE_LAT = NSTEP + 1;

  // cross product
  localparam int PW = 2 * OUT_W;
  localparam int DW = PW + 1;

endpackage
`default_nettype wire

### design/obv_norm_lane.sv
`default_nettype none
// one normalized component: round(a * 2^f / sqrt(s)), one result bit per stage
module obv_norm_lane (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [obv_pkg::SW-1:0]          sum_i,
  input  wire logic [obv_pkg::SQW-1:0]         sq_i,
  input  wire logic                            neg_i,
  output logic signed [obv_pkg::OUT_W-1:0]     q_o
);

  localparam int RW    = obv_pkg::RW;
  localparam int WW    = obv_pkg::WW;
  localparam int SW    = obv_pkg::SW;
  localparam int SQW   = obv_pkg::SQW;
  localparam int MQW   = obv_pkg::MQW;
  localparam int NSTEP = obv_pkg::NSTEP;
  localparam int F     = obv_pkg::FRAC_BITS;

  // init stage: remainder t - s for a trial value of zero, cross term -s
  logic signed [RW-1:0] r0_q;
  logic signed [WW-1:0] w0_q;
  logic [SW-1:0]        s0_q;
  logic                 n0_q;

  logic [RW-1:0] t_ext;
  logic [RW-1:0] s_ext0;
  logic [WW-1:0] s_w0;

  assign t_ext  = {{(RW-SQW-2*F-2){1'b0}}, sq_i, {(2*F+2){1'b0}}};
  assign s_ext0 = {{(RW-SW){1'b0}}, sum_i};
  assign s_w0   = {{(WW-SW){1'b0}}, sum_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q <= signed'(t_ext - s_ext0);
      w0_q <= signed'(-s_w0);
      s0_q <= sum_i;
      n0_q <= neg_i;
    end
  end

  logic signed [RW-1:0] r_q [NSTEP];
  logic signed [WW-1:0] w_q [NSTEP];
  logic [SW-1:0]        s_q [NSTEP];
  logic [MQW-1:0]       m_q [NSTEP];
  logic                 n_q [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam int B = F - i;
    logic signed [RW-1:0] r_in;
    logic signed [WW-1:0] w_in;
    logic [SW-1:0]        s_in;
    logic [MQW-1:0]       m_in;
    logic                 n_in;
    logic [RW-1:0]        w_ext;
    logic [RW-1:0]        s_ext;
    logic [WW-1:0]        s_wext;
    logic [RW-1:0]        trial;
    logic                 take;

    if (i == 0) begin : g_first
      assign r_in = r0_q;
      assign w_in = w0_q;
      assign s_in = s0_q;
      assign m_in = '0;
      assign n_in = n0_q;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign w_in = w_q[i-1];
      assign s_in = s_q[i-1];
      assign m_in = m_q[i-1];
      assign n_in = n_q[i-1];
    end

    assign w_ext  = {{(RW-WW){w_in[WW-1]}}, w_in};
    assign s_ext  = {{(RW-SW){1'b0}}, s_in};
    assign s_wext = {{(WW-SW){1'b0}}, s_in};
    // (2m+2^(b+1)-1)^2 s = (2m-1)^2 s + 2^(b+2) w + 2^(2b+2) s
    assign trial  = r_in - (w_ext << (B + 2)) - (s_ext << (2 * B + 2));
    assign take   = ~trial[RW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= take ? signed'(trial) : r_in;
        w_q[i] <= take ? signed'(w_in + (s_wext << (B + 1))) : w_in;
        m_q[i] <= m_in | (take ? MQW'(1) << B : MQW'(0));
        s_q[i] <= s_in;
        n_q[i] <= n_in;
      end
    end
  end

  logic [obv_pkg::OUT_W-1:0] mag;
  assign mag = {{(obv_pkg::OUT_W-MQW){1'b0}}, m_q[NSTEP-1]};
  assign q_o = signed'(n_q[NSTEP-1] ? -mag : mag);

endmodule
`default_nettype wire

### design/orthonormal_basis_from_vector.sv
// a request passes the input, magnitude, square and sum registers, the 16-stage
// normalizing lane (init + 15 square root steps), product and output registers
// one request per cycle when not stalled, every step has its own register stage
// a stall on the output holds the whole pipeline in place
// reset clears only the valid bits, data registers are not reset
`default_nettype none
module orthonormal_basis_from_vector (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // dir_x, dir_y, dir_z
  input  wire logic [47:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z
  output logic [143:0]      m_axis_tdata,
  // zero_input
  output logic [0:0]        m_axis_tuser
);

  localparam int IW    = obv_pkg::IN_WIDTH;
  localparam int MW    = obv_pkg::MW;
  localparam int SQW   = obv_pkg::SQW;
  localparam int SW    = obv_pkg::SW;
  localparam int OW    = obv_pkg::OUT_W;
  localparam int PW    = obv_pkg::PW;
  localparam int DW    = obv_pkg::DW;
  localparam int F     = obv_pkg::FRAC_BITS;
  // input, magnitude, square, sum, lanes, products, output
  localparam int NPIPE = obv_pkg::LANE_LAT + 6;

  // round half away from zero to f fraction bits, saturate magnitude to 2^f
  function automatic logic signed [OW-1:0] round_cross(input logic signed [PW-1:0] a,
                                                       input logic signed [PW-1:0] b);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    logic [DW-1:0]        r;
    logic [OW-1:0]        rs;
    d = {a[PW-1], a} - {b[PW-1], b};
    m = d[DW-1] ? -d : d;
    r = (m + (DW'(1) << (F - 1))) >> F;
    if (r > (DW'(1) << F)) begin
      r = DW'(1) << F;
    end
    rs = r[OW-1:0];
    return signed'(d[DW-1] ? -rs : rs);
  endfunction

  // pipeline control: everything advances together
  logic en;
  logic vld_q  [NPIPE];
  logic zero_q [NPIPE-1];

  assign en            = ~vld_q[NPIPE-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NPIPE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NPIPE; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NPIPE; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // input register
  logic signed [IW-1:0] dir_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q[0] <= signed'(s_axis_tdata[IW-1:0]);
      dir_q[1] <= signed'(s_axis_tdata[2*IW-1:IW]);
      dir_q[2] <= signed'(s_axis_tdata[3*IW-1:2*IW]);
    end
  end

  // magnitudes and perpendicular choice (lanes 0..2 first, 3..5 second)
  logic [MW-1:0] ax, ay, az;
  logic          nx, ny, nz;
  logic [MW-1:0] mag_d [6];
  logic          neg_d [6];
  logic          zero_d;

  assign nx = dir_q[0][IW-1];
  assign ny = dir_q[1][IW-1];
  assign nz = dir_q[2][IW-1];
  assign ax = nx ? -dir_q[0] : dir_q[0];
  assign ay = ny ? -dir_q[1] : dir_q[1];
  assign az = nz ? -dir_q[2] : dir_q[2];
  assign zero_d = (ax == '0) && (ay == '0) && (az == '0);

  always_comb begin
    mag_d[0] = ax; neg_d[0] = nx;
    mag_d[1] = ay; neg_d[1] = ny;
    mag_d[2] = az; neg_d[2] = nz;
    // smallest component dropped, ties go to x then y
    priority if (ax <= ay && ax <= az) begin
      mag_d[3] = '0; neg_d[3] = 1'b0;
      mag_d[4] = az; neg_d[4] = ~nz;
      mag_d[5] = ay; neg_d[5] = ny;
    end else if (ay <= ax && ay <= az) begin
      mag_d[3] = az; neg_d[3] = ~nz;
      mag_d[4] = '0; neg_d[4] = 1'b0;
      mag_d[5] = ax; neg_d[5] = nx;
    end else begin
      mag_d[3] = ay; neg_d[3] = ~ny;
      mag_d[4] = ax; neg_d[4] = nx;
      mag_d[5] = '0; neg_d[5] = 1'b0;
    end
  end

  logic [MW-1:0]  mag1_q [6];
  logic           neg1_q [6];
  logic [SQW-1:0] sq2_q  [6];
  logic           neg2_q [6];
  logic [SQW-1:0] sq3_q  [6];
  logic           neg3_q [6];
  logic [SW-1:0]  sum3_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        mag1_q[i] <= mag_d[i];
        neg1_q[i] <= neg_d[i];
        sq2_q[i]  <= mag1_q[i] * mag1_q[i];
        neg2_q[i] <= neg1_q[i];
        sq3_q[i]  <= sq2_q[i];
        neg3_q[i] <= neg2_q[i];
      end
      sum3_q[0] <= SW'(sq2_q[0]) + SW'(sq2_q[1]) + SW'(sq2_q[2]);
      sum3_q[1] <= SW'(sq2_q[3]) + SW'(sq2_q[4]) + SW'(sq2_q[5]);
    end
  end

  // zero flag travels with the valid bits from the magnitude stage on
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= zero_d;
      for (int i = 1; i < NPIPE - 1; i++) zero_q[i] <= zero_q[i-1];
    end
  end

  // six normalizing lanes
  logic signed [OW-1:0] q [6];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    obv_norm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .sum_i  (sum3_q[l / 3]),
      .sq_i   (sq3_q[l]),
      .neg_i  (neg3_q[l]),
      .q_o    (q[l])
    );
  end

  // cross product terms
  logic signed [OW-1:0] f_q  [3];
  logic signed [OW-1:0] g_q  [3];
  logic signed [PW-1:0] pr_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_q[i] <= q[i];
        g_q[i] <= q[3+i];
      end
      pr_q[0] <= q[1] * q[5];
      pr_q[1] <= q[2] * q[4];
      pr_q[2] <= q[2] * q[3];
      pr_q[3] <= q[0] * q[5];
      pr_q[4] <= q[0] * q[4];
      pr_q[5] <= q[1] * q[3];
    end
  end

  // output register, axes forced to zero for a zero vector
  logic [143:0] data_d;
  logic [143:0] data_q;
  logic         zmask;

  assign zmask = zero_q[NPIPE-3];

  always_comb begin
    data_d = {round_cross(pr_q[4], pr_q[5]), round_cross(pr_q[2], pr_q[3]),
              round_cross(pr_q[0], pr_q[1]),
              g_q[2], g_q[1], g_q[0], f_q[2], f_q[1], f_q[0]};
    if (zmask) begin
      data_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = zero_q[NPIPE-2];

endmodule
`default_nettype wire
